FILE: design/ip_literal_validator_defines.svh
// assertion macros for the ip literal validator
`ifndef IP_LITERAL_VALIDATOR_DEFINES_SVH
`define IP_LITERAL_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ILV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("ilv check failed");
`define ILV_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("ilv forbidden condition seen");
`else
`define ILV_ASSERT(lbl, clk, rst_n, prop)
`define ILV_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: design/ilv_pkg.sv
// shared types, character codes and helpers of the ip literal validator
`default_nettype none
package ilv_pkg;

	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOW_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_F    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UP_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F     = 8'h46;

	localparam logic [2:0] PREFIX_LEN = 3'd5;
	localparam logic [8:0] V4_PART_MAX = 9'd255;
	localparam logic [8:0] V4_PART_OVER = 9'd256;
	localparam logic [2:0] V4_DOTS_NEEDED = 3'd3;
	localparam logic [2:0] V4_DOTS_SAT = 3'd7;
	localparam logic [2:0] V6_LEN_MAX = 3'd4;
	localparam logic [2:0] V6_LEN_SAT = 3'd5;
	localparam logic [3:0] V6_GROUPS_FULL = 4'd8;
	localparam logic [3:0] V6_GROUPS_SHORT_MAX = 4'd7;
	localparam logic [3:0] V6_GROUPS_SAT = 4'd15;
	localparam logic [1:0] COUNT_SAT = 2'd2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BRACKET = 2'd1,
		ST_BAD_V6  = 2'd2,
		ST_BAD_V4  = 2'd3
	} status_t;

	// colon history of the ipv6 scan
	typedef enum logic [1:0] {
		COLON_NONE   = 2'd0,
		COLON_SINGLE = 2'd1,
		COLON_DOUBLE = 2'd2,
		COLON_LOCKED = 2'd3
	} colon_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_in;
		logic              last_char;
	} beat_t;

	typedef struct packed {
		logic    is_valid;
		status_t status;
	} result_t;

	typedef struct packed {
		logic [1:0]        char_count;
		logic              opened_ok;
		logic [CHAR_W-1:0] held_char;
		logic              held_valid;
		logic [2:0]        prefix_progress;
		logic              prefix_failed;
		logic [8:0]        v4_part_value;
		logic [2:0]        v4_dot_count;
		logic              v4_prev_dot_or_start;
		logic              v4_error;
		logic [2:0]        v6_group_len;
		logic [3:0]        v6_group_count;
		logic              v6_saw_double;
		colon_t            v6_prev_colon;
		logic              v6_at_start;
		logic              v6_error;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		char_count:           2'd0,
		opened_ok:            1'b0,
		held_char:            '0,
		held_valid:           1'b0,
		prefix_progress:      3'd0,
		prefix_failed:        1'b0,
		v4_part_value:        9'd0,
		v4_dot_count:         3'd0,
		v4_prev_dot_or_start: 1'b1,
		v4_error:             1'b0,
		v6_group_len:         3'd0,
		v6_group_count:       4'd0,
		v6_saw_double:        1'b0,
		v6_prev_colon:        COLON_NONE,
		v6_at_start:          1'b1,
		v6_error:             1'b0
	};

	// "IPv6:" one character at a time
	function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] idx);
		logic [CHAR_W-1:0] ch;
		unique case (idx)
			3'd0: ch = 8'h49;
			3'd1: ch = 8'h50;
			3'd2: ch = 8'h76;
			3'd3: ch = 8'h36;
			3'd4: ch = 8'h3A;
			default: ch = '0;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [CHAR_W-1:0] c);
		return is_digit(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
			((c >= CH_UP_A) && (c <= CH_UP_F));
	endfunction

endpackage
`default_nettype wire

FILE: design/ilv_char_if.sv
// character channel: one literal character per beat
`default_nettype none
interface ilv_char_if;
	logic                      valid;
	logic                      ready;
	logic [ilv_pkg::CHAR_W-1:0] char_in;
	logic                      last_char;

	modport source(output valid, output char_in, output last_char, input ready);
	modport sink(input valid, input char_in, input last_char, output ready);
endinterface
`default_nettype wire

FILE: design/ilv_result_if.sv
// result channel: one verdict beat per literal
`default_nettype none
interface ilv_result_if;
	logic       valid;
	logic       ready;
	logic       is_valid;
	logic [1:0] status;

	modport source(output valid, output is_valid, output status, input ready);
	modport sink(input valid, input is_valid, input status, output ready);
endinterface
`default_nettype wire

FILE: design/ilv_in_stage.sv
// input register stage with stall control toward the scanner
`default_nettype none
module ilv_in_stage (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ilv_char_if.sink      chars,
	input  wire logic     out_free,
	output logic          fire,
	output ilv_pkg::beat_t beat
);

	logic           valid_s1;
	ilv_pkg::beat_t beat_s1;

	// only a closing beat needs room in the result register
	assign fire = valid_s1 && (!beat_s1.last_char || out_free);
	assign chars.ready = !valid_s1 || fire;
	assign beat = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			beat_s1.char_in <= chars.char_in;
			beat_s1.last_char <= chars.last_char;
		end
	end

endmodule
`default_nettype wire

FILE: design/ilv_scanner.sv
// running literal state and the verdict on the closing character
`default_nettype none
module ilv_scanner (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire ilv_pkg::beat_t  beat,
	output logic                 res_valid,
	output ilv_pkg::result_t     res
);

	ilv_pkg::scan_t scan_q;
	ilv_pkg::scan_t scan_d;

	function automatic ilv_pkg::scan_t v4_feed(input ilv_pkg::scan_t s,
			input logic [ilv_pkg::CHAR_W-1:0] c);
		ilv_pkg::scan_t n;
		logic [11:0] prod;
		n = s;
		prod = ({3'b000, s.v4_part_value} << 3) + ({3'b000, s.v4_part_value} << 1) +
			{8'd0, c[3:0] - ilv_pkg::CH_ZERO[3:0]};
		if (c == ilv_pkg::CH_DOT) begin
			if (s.v4_prev_dot_or_start)
				n.v4_error = 1'b1;
			if (s.v4_dot_count < ilv_pkg::V4_DOTS_SAT)
				n.v4_dot_count = s.v4_dot_count + 3'd1;
			n.v4_part_value = 9'd0;
			n.v4_prev_dot_or_start = 1'b1;
		end else if (ilv_pkg::is_digit(c)) begin
			if (prod > {3'b000, ilv_pkg::V4_PART_MAX}) begin
				n.v4_error = 1'b1;
				n.v4_part_value = ilv_pkg::V4_PART_OVER;
			end else begin
				n.v4_part_value = prod[8:0];
			end
			n.v4_prev_dot_or_start = 1'b0;
		end else begin
			n.v4_error = 1'b1;
			n.v4_prev_dot_or_start = 1'b0;
		end
		return n;
	endfunction

	function automatic ilv_pkg::scan_t v6_feed(input ilv_pkg::scan_t s,
			input logic [ilv_pkg::CHAR_W-1:0] c);
		ilv_pkg::scan_t n;
		logic [2:0] len;
		n = s;
		len = s.v6_group_len;
		if (c == ilv_pkg::CH_COLON) begin
			if (s.v6_prev_colon == ilv_pkg::COLON_SINGLE ||
					s.v6_prev_colon == ilv_pkg::COLON_LOCKED) begin
				if (s.v6_saw_double)
					n.v6_error = 1'b1;
				n.v6_saw_double = 1'b1;
				n.v6_prev_colon = ilv_pkg::COLON_DOUBLE;
			end else if (s.v6_prev_colon == ilv_pkg::COLON_DOUBLE) begin
				n.v6_prev_colon = ilv_pkg::COLON_LOCKED;
			end else begin
				if (s.v6_group_len != 3'd0 && s.v6_group_count < ilv_pkg::V6_GROUPS_SAT)
					n.v6_group_count = s.v6_group_count + 4'd1;
				// a colon right after the prefix must open a "::"
				n.v6_prev_colon = s.v6_at_start ? ilv_pkg::COLON_LOCKED
					: ilv_pkg::COLON_SINGLE;
			end
			n.v6_group_len = 3'd0;
		end else begin
			if (s.v6_prev_colon == ilv_pkg::COLON_LOCKED)
				n.v6_error = 1'b1;
			n.v6_prev_colon = ilv_pkg::COLON_NONE;
			if (!ilv_pkg::is_hex(c))
				n.v6_error = 1'b1;
			if (len < ilv_pkg::V6_LEN_SAT)
				len = len + 3'd1;
			if (len > ilv_pkg::V6_LEN_MAX)
				n.v6_error = 1'b1;
			n.v6_group_len = len;
		end
		n.v6_at_start = 1'b0;
		return n;
	endfunction

	function automatic ilv_pkg::scan_t inner_feed(input ilv_pkg::scan_t s,
			input logic [ilv_pkg::CHAR_W-1:0] c);
		ilv_pkg::scan_t n;
		n = s;
		if (s.prefix_progress >= ilv_pkg::PREFIX_LEN) begin
			n = v6_feed(s, c);
		end else begin
			if (!s.prefix_failed) begin
				if (c == ilv_pkg::prefix_char(s.prefix_progress))
					n.prefix_progress = s.prefix_progress + 3'd1;
				else
					n.prefix_failed = 1'b1;
			end
			n = v4_feed(n, c);
		end
		return n;
	endfunction

	function automatic logic v6_ok(input ilv_pkg::scan_t s);
		logic err;
		logic [3:0] cnt;
		err = s.v6_error;
		cnt = s.v6_group_count;
		if (s.v6_prev_colon == ilv_pkg::COLON_SINGLE ||
				s.v6_prev_colon == ilv_pkg::COLON_LOCKED)
			err = 1'b1;
		if (s.v6_group_len != 3'd0 && cnt < ilv_pkg::V6_GROUPS_SAT)
			cnt = cnt + 4'd1;
		if (s.v6_saw_double) begin
			if (cnt > ilv_pkg::V6_GROUPS_SHORT_MAX)
				err = 1'b1;
		end else if (cnt != ilv_pkg::V6_GROUPS_FULL) begin
			err = 1'b1;
		end
		return !err;
	endfunction

	function automatic logic v4_ok(input ilv_pkg::scan_t s);
		return !s.v4_error && !s.v4_prev_dot_or_start &&
			(s.v4_dot_count == ilv_pkg::V4_DOTS_NEEDED);
	endfunction

	ilv_pkg::scan_t  fed;
	ilv_pkg::status_t status;

	// inner text runs one character behind, so the closer never reaches it
	always_comb begin
		fed = scan_q;
		if (scan_q.char_count == 2'd0)
			fed.opened_ok = (beat.char_in == ilv_pkg::CH_LBRACKET);
		else if (scan_q.held_valid)
			fed = inner_feed(scan_q, scan_q.held_char);

		if (scan_q.char_count == 2'd0 || !fed.opened_ok ||
				beat.char_in != ilv_pkg::CH_RBRACKET)
			status = ilv_pkg::ST_BRACKET;
		else if (fed.prefix_progress >= ilv_pkg::PREFIX_LEN)
			status = v6_ok(fed) ? ilv_pkg::ST_OK : ilv_pkg::ST_BAD_V6;
		else
			status = v4_ok(fed) ? ilv_pkg::ST_OK : ilv_pkg::ST_BAD_V4;

		scan_d = fed;
		if (beat.last_char) begin
			scan_d = ilv_pkg::SCAN_RESET;
		end else begin
			if (scan_q.char_count != 2'd0) begin
				scan_d.held_char = beat.char_in;
				scan_d.held_valid = 1'b1;
			end
			if (scan_q.char_count < ilv_pkg::COUNT_SAT)
				scan_d.char_count = scan_q.char_count + 2'd1;
		end
	end

	assign res_valid = fire && beat.last_char;
	assign res.is_valid = (status == ilv_pkg::ST_OK);
	assign res.status = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= ilv_pkg::SCAN_RESET;
		end else if (fire) begin
			scan_q <= scan_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/ilv_out_stage.sv
// result register toward the output channel
`default_nettype none
module ilv_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire ilv_pkg::result_t  res,
	ilv_result_if.source           results,
	output logic                   out_free
);

	logic             valid_q;
	ilv_pkg::result_t res_q;

	assign out_free = !valid_q || results.ready;
	assign results.valid = valid_q;
	assign results.is_valid = res_q.is_valid;
	assign results.status = res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

FILE: design/ip_literal_validator.sv
// a closing character goes from the input register to the scanner, whose verdict is registered
// throughput: one character per cycle, each updating the running state, unless a closer stalls
// the input register keeps taking characters while a verdict waits in the result register
// only a closing character stalls, and only while the result register is still full
// reset: arst_n clears the input, scan and result stages at once; the scan restarts per literal
`default_nettype none
`include "ip_literal_validator_defines.svh"
module ip_literal_validator (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ilv_char_if.sink     chars,
	ilv_result_if.source results
);

	logic             fire;
	logic             out_free;
	logic             res_valid;
	ilv_pkg::beat_t   beat;
	ilv_pkg::result_t res;

	ilv_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.out_free (out_free),
		.fire     (fire),
		.beat     (beat)
	);

	ilv_scanner u_scanner (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.beat      (beat),
		.res_valid (res_valid),
		.res       (res)
	);

	ilv_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.results   (results),
		.out_free  (out_free)
	);

	`ILV_ASSERT(a_no_overwrite, clk, arst_n, res_valid |-> out_free)
	`ILV_ASSERT(a_flag_matches_code, clk, arst_n, results.valid |-> (results.is_valid == (results.status == ilv_pkg::ST_OK)))
	`ILV_ASSERT(a_stalled_beat_held, clk, arst_n, (!chars.ready) |=> $stable(beat))
	`ILV_ASSERT_NEVER(a_result_only_on_close, clk, arst_n, res_valid && !beat.last_char)

endmodule
`default_nettype wire
